// ----- hdl/m4te_pkg.sv -----
// ============================================================================
// m4te_pkg
// Shared types, constants and helper functions for the 4x4 matrix engine.
// ============================================================================
`default_nettype none

package m4te_pkg;

    localparam int DATA_W      = 32;
    localparam int MAT_ENTRIES = 16;
    localparam int ADDR_W      = 4;
    localparam int STEP_W      = 6;
    localparam int FRAC_BITS_DEFAULT = 16;

    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_ADD    = 3'd1,
        OP_SUB    = 3'd2,
        OP_MATMUL = 3'd3,
        OP_SCALE  = 3'd4,
        OP_XFORM  = 3'd5,
        OP_DET    = 3'd6,
        OP_IDENT  = 3'd7
    } op_t;

    localparam logic KIND_VECTOR = 1'b0;
    localparam logic KIND_DET    = 1'b1;

    // Micro-step phases of the determinant term loop.
    localparam logic [1:0] DSUB_MINOR_A = 2'd0;
    localparam logic [1:0] DSUB_MINOR_B = 2'd1;
    localparam logic [1:0] DSUB_PAIR    = 2'd2;
    localparam logic [1:0] DSUB_TERM    = 2'd3;

    typedef struct packed {
        logic [1:0] i;
        logic [1:0] j;
        logic [1:0] k1;
        logic [1:0] k2;
        logic       neg;
    } det_term_t;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
        logic signed [63:0] max_v;
        logic signed [63:0] min_v;
        max_v = 64'sd2147483647;
        min_v = -64'sd2147483648;
        if (x > max_v)
            sat32 = 32'sh7FFFFFFF;
        else if (x < min_v)
            sat32 = 32'sh80000000;
        else
            sat32 = x[DATA_W-1:0];
    endfunction

    // Laplace expansion term table: row-0 column i, row-1 column j, remaining
    // columns k1 < k2 for the rows 2/3 minor, and the cofactor sign.
    function automatic det_term_t det_term(input logic [3:0] p);
        det_term_t t;
        t = '0;
        case (p)
            4'd0:    t = '{i: 2'd0, j: 2'd1, k1: 2'd2, k2: 2'd3, neg: 1'b0};
            4'd1:    t = '{i: 2'd0, j: 2'd2, k1: 2'd1, k2: 2'd3, neg: 1'b1};
            4'd2:    t = '{i: 2'd0, j: 2'd3, k1: 2'd1, k2: 2'd2, neg: 1'b0};
            4'd3:    t = '{i: 2'd1, j: 2'd0, k1: 2'd2, k2: 2'd3, neg: 1'b1};
            4'd4:    t = '{i: 2'd1, j: 2'd2, k1: 2'd0, k2: 2'd3, neg: 1'b0};
            4'd5:    t = '{i: 2'd1, j: 2'd3, k1: 2'd0, k2: 2'd2, neg: 1'b1};
            4'd6:    t = '{i: 2'd2, j: 2'd0, k1: 2'd1, k2: 2'd3, neg: 1'b0};
            4'd7:    t = '{i: 2'd2, j: 2'd1, k1: 2'd0, k2: 2'd3, neg: 1'b1};
            4'd8:    t = '{i: 2'd2, j: 2'd3, k1: 2'd0, k2: 2'd1, neg: 1'b0};
            4'd9:    t = '{i: 2'd3, j: 2'd0, k1: 2'd1, k2: 2'd2, neg: 1'b1};
            4'd10:   t = '{i: 2'd3, j: 2'd1, k1: 2'd0, k2: 2'd2, neg: 1'b0};
            4'd11:   t = '{i: 2'd3, j: 2'd2, k1: 2'd0, k2: 2'd1, neg: 1'b1};
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/m4te_if.sv -----
// ============================================================================
// m4te_if
// Valid/ready channel interfaces for engine commands and results.
// ============================================================================
`default_nettype none

interface m4te_cmd_if;
    logic                 valid;
    logic                 ready;
    logic [2:0]           opcode;
    logic [1:0]           column_index;
    logic signed [31:0]   elem_0;
    logic signed [31:0]   elem_1;
    logic signed [31:0]   elem_2;
    logic signed [31:0]   elem_3;

    modport source (output valid, opcode, column_index, elem_0, elem_1, elem_2, elem_3,
                    input ready);
    modport sink   (input valid, opcode, column_index, elem_0, elem_1, elem_2, elem_3,
                    output ready);
endinterface

interface m4te_rsp_if;
    logic                 valid;
    logic                 ready;
    logic                 result_kind;
    logic signed [31:0]   out_0;
    logic signed [31:0]   out_1;
    logic signed [31:0]   out_2;
    logic signed [31:0]   out_3;

    modport source (output valid, result_kind, out_0, out_1, out_2, out_3, input ready);
    modport sink   (input valid, result_kind, out_0, out_1, out_2, out_3, output ready);
endinterface

`default_nettype wire

// ----- hdl/m4te_ram.sv -----
// ============================================================================
// m4te_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ============================================================================
`default_nettype none

module m4te_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- hdl/matrix4_transform_engine_core.sv -----
// ============================================================================
// matrix4_transform_engine_core
// 4x4 signed fixed-point matrix unit built around small synchronous RAMs.
// ============================================================================
//
// Usage: commands arrive on the item channel, one transaction per command.
// Load, add, subtract, scale and identity update the held matrix, matmul
// column fills the product buffer, and all of them return nothing; transform
// vector and determinant return one transaction on the result channel.
// Every command runs as a series of micro-steps (read the RAMs, multiply on
// the single shared 32x32 multiplier, accumulate and write back). There are
// 4 micro-steps for load, add and subtract, 16 for identity, scale, transform
// and matmul column, 32 for the matmul column that carries column 3 (it also
// copies the product buffer into the held matrix), and 48 for the determinant.
// Transform and determinant then pass through the finish state, which loads
// the result into the output register once that register is free.
// The single multiplier and the one-entry-per-step RAM port set these counts.
// At reset the held matrix reads as all zeros (per-entry valid bits are
// cleared), and no result is pending. When the receiver stalls, the result
// stays in the output register; further commands are still accepted and
// processed, but the next result waits in its finish state until the
// output register drains.
//
`default_nettype none

module matrix4_transform_engine_core #(
    parameter int FRAC_BITS = m4te_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    m4te_cmd_if.sink   item,
    m4te_rsp_if.source result
);

    localparam int DW = m4te_pkg::DATA_W;
    localparam int AW = m4te_pkg::ADDR_W;
    localparam int SW = m4te_pkg::STEP_W;
    localparam logic signed [DW-1:0] ONE_Q = DW'(1) << FRAC_BITS;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RD   = 5'b00010,
        ST_EX   = 5'b00100,
        ST_AC   = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    m4te_pkg::op_t          op_reg;
    logic [1:0]             col_reg;
    logic signed [DW-1:0]   elem_reg [4];
    logic                   copy_reg, copy_next;
    logic [SW-1:0]          step_reg, step_next;
    logic signed [63:0]     prod_reg;
    logic signed [63:0]     acc_reg;
    logic signed [63:0]     t1_reg;
    logic signed [DW-1:0]   minor_reg;
    logic signed [DW-1:0]   pair_reg;
    logic signed [DW-1:0]   res_reg [4];
    logic [m4te_pkg::MAT_ENTRIES-1:0] valid_reg;
    logic                   vld_a_reg, vld_b_reg;

    logic                   out_vld_reg;
    logic                   out_kind_reg;
    logic signed [DW-1:0]   out_data_reg [4];

    logic                   accept;
    logic                   emit_load;
    logic [SW-1:0]          last_step;
    logic [1:0]             sub;
    logic [3:0]             term_idx;
    m4te_pkg::det_term_t    dt;

    logic [AW-1:0]          addr_a, addr_b;
    logic [DW-1:0]          held_a_q, held_b_q, pb_q;
    logic signed [DW-1:0]   ha, hb, er;
    logic signed [DW-1:0]   mul_a, mul_b;
    logic signed [63:0]     mul_full;
    logic signed [32:0]     addsub;
    logic signed [63:0]     row_sum, det_sum, minor_diff;

    logic                   held_we;
    logic [DW-1:0]          held_wd;
    logic                   pb_we;
    logic [AW-1:0]          pb_wa;
    logic [DW-1:0]          pb_wd;

    assign accept     = item.valid && item.ready;
    assign item.ready = (state_reg == ST_IDLE);
    assign emit_load  = (state_reg == ST_EMIT) && (!out_vld_reg || result.ready);

    assign sub      = step_reg[1:0];
    assign term_idx = step_reg[5:2];
    assign dt       = m4te_pkg::det_term(term_idx);

    always_comb
    begin
        last_step = SW'(15);
        if (!copy_reg)
        begin
            case (op_reg)
                m4te_pkg::OP_LOAD,
                m4te_pkg::OP_ADD,
                m4te_pkg::OP_SUB:   last_step = SW'(3);
                m4te_pkg::OP_DET:   last_step = SW'(47);
                default:            last_step = SW'(15);
            endcase
        end
    end

    // Read addresses; element (row r, column c) lives at r + 4*c = {c, r}.
    always_comb
    begin
        addr_a = step_reg[AW-1:0];
        if (!copy_reg)
        begin
            case (op_reg)
                m4te_pkg::OP_LOAD,
                m4te_pkg::OP_ADD,
                m4te_pkg::OP_SUB:    addr_a = {col_reg, step_reg[1:0]};
                m4te_pkg::OP_MATMUL,
                m4te_pkg::OP_XFORM:  addr_a = {step_reg[1:0], step_reg[3:2]};
                m4te_pkg::OP_DET:
                begin
                    case (sub)
                        m4te_pkg::DSUB_MINOR_A: addr_a = {dt.k1, 2'd2};
                        m4te_pkg::DSUB_MINOR_B: addr_a = {dt.k1, 2'd3};
                        default:                addr_a = {dt.i, 2'd0};
                    endcase
                end
                default:             addr_a = step_reg[AW-1:0];
            endcase
        end
    end

    always_comb
    begin
        case (sub)
            m4te_pkg::DSUB_MINOR_A: addr_b = {dt.k2, 2'd3};
            m4te_pkg::DSUB_MINOR_B: addr_b = {dt.k2, 2'd2};
            default:                addr_b = {dt.j, 2'd1};
        endcase
    end

    // Two copies of the held matrix give two read ports; both get every write.
    m4te_ram #(.WIDTH(DW), .DEPTH(m4te_pkg::MAT_ENTRIES)) u_held_a (
        .clk     (clk),
        .wr_en   (held_we),
        .wr_addr (addr_a),
        .wr_data (held_wd),
        .rd_addr (addr_a),
        .rd_data (held_a_q)
    );

    m4te_ram #(.WIDTH(DW), .DEPTH(m4te_pkg::MAT_ENTRIES)) u_held_b (
        .clk     (clk),
        .wr_en   (held_we),
        .wr_addr (addr_a),
        .wr_data (held_wd),
        .rd_addr (addr_b),
        .rd_data (held_b_q)
    );

    m4te_ram #(.WIDTH(DW), .DEPTH(m4te_pkg::MAT_ENTRIES)) u_prod_buf (
        .clk     (clk),
        .wr_en   (pb_we),
        .wr_addr (pb_wa),
        .wr_data (pb_wd),
        .rd_addr (step_reg[AW-1:0]),
        .rd_data (pb_q)
    );

    // Entries never written since reset read as zero.
    assign ha = vld_a_reg ? $signed(held_a_q) : '0;
    assign hb = vld_b_reg ? $signed(held_b_q) : '0;
    assign er = elem_reg[step_reg[1:0]];

    // Shared multiplier operand selection (used in the execute phase).
    always_comb
    begin
        mul_a = ha;
        mul_b = er;
        case (op_reg)
            m4te_pkg::OP_SCALE: mul_b = elem_reg[0];
            m4te_pkg::OP_DET:
            begin
                if (sub == m4te_pkg::DSUB_TERM)
                begin
                    mul_a = pair_reg;
                    mul_b = minor_reg;
                end
                else
                begin
                    mul_b = hb;
                end
            end
            default: mul_b = er;
        endcase
    end

    assign mul_full = 64'(mul_a) * 64'(mul_b);

    assign addsub     = (op_reg == m4te_pkg::OP_ADD) ? (33'(ha) + 33'(er))
                                                      : (33'(ha) - 33'(er));
    assign row_sum    = ((sub == 2'd0) ? 64'sd0 : acc_reg) + prod_reg;
    assign det_sum    = dt.neg ? (((term_idx == 4'd0) ? 64'sd0 : acc_reg) - prod_reg)
                               : (((term_idx == 4'd0) ? 64'sd0 : acc_reg) + prod_reg);
    assign minor_diff = t1_reg - prod_reg;

    // Write-back to the held matrix in the accumulate phase.
    always_comb
    begin
        held_we = 1'b0;
        held_wd = '0;
        if (state_reg == ST_AC)
        begin
            if (copy_reg)
            begin
                held_we = 1'b1;
                held_wd = pb_q;
            end
            else
            begin
                case (op_reg)
                    m4te_pkg::OP_LOAD:
                    begin
                        held_we = 1'b1;
                        held_wd = er;
                    end
                    m4te_pkg::OP_ADD,
                    m4te_pkg::OP_SUB:
                    begin
                        held_we = 1'b1;
                        held_wd = m4te_pkg::sat32(64'(addsub));
                    end
                    m4te_pkg::OP_SCALE:
                    begin
                        held_we = 1'b1;
                        held_wd = m4te_pkg::sat32(prod_reg);
                    end
                    m4te_pkg::OP_IDENT:
                    begin
                        held_we = 1'b1;
                        held_wd = (step_reg[1:0] == step_reg[3:2]) ? ONE_Q : '0;
                    end
                    default: held_we = 1'b0;
                endcase
            end
        end
    end

    assign pb_we = (state_reg == ST_AC) && !copy_reg && (op_reg == m4te_pkg::OP_MATMUL)
                   && (sub == 2'd3);
    assign pb_wa = {col_reg, step_reg[3:2]};
    assign pb_wd = m4te_pkg::sat32(row_sum);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        copy_next  = copy_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RD;
                    step_next  = '0;
                    copy_next  = 1'b0;
                end
            end
            ST_RD: state_next = ST_EX;
            ST_EX: state_next = ST_AC;
            ST_AC:
            begin
                if (step_reg == last_step)
                begin
                    step_next = '0;
                    if (!copy_reg && (op_reg == m4te_pkg::OP_MATMUL) && (col_reg == 2'd3))
                    begin
                        copy_next  = 1'b1;
                        state_next = ST_RD;
                    end
                    else if ((op_reg == m4te_pkg::OP_XFORM) || (op_reg == m4te_pkg::OP_DET))
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    step_next  = step_reg + SW'(1);
                    state_next = ST_RD;
                end
            end
            ST_EMIT:
            begin
                if (emit_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            copy_reg    <= 1'b0;
            valid_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            copy_reg  <= copy_next;
            if (held_we)
            begin
                valid_reg[addr_a] <= 1'b1;
            end
            if (emit_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload and datapath registers.
    always_ff @(posedge clk)
    begin
        vld_a_reg <= valid_reg[addr_a];
        vld_b_reg <= valid_reg[addr_b];
        if (accept)
        begin
            op_reg      <= m4te_pkg::op_t'(item.opcode);
            col_reg     <= item.column_index;
            elem_reg[0] <= item.elem_0;
            elem_reg[1] <= item.elem_1;
            elem_reg[2] <= item.elem_2;
            elem_reg[3] <= item.elem_3;
        end
        if (state_reg == ST_EX)
        begin
            prod_reg <= mul_full >>> FRAC_BITS;
        end
        if ((state_reg == ST_AC) && !copy_reg)
        begin
            case (op_reg)
                m4te_pkg::OP_MATMUL: acc_reg <= row_sum;
                m4te_pkg::OP_XFORM:
                begin
                    acc_reg <= row_sum;
                    if (sub == 2'd3)
                    begin
                        res_reg[step_reg[3:2]] <= m4te_pkg::sat32(row_sum);
                    end
                end
                m4te_pkg::OP_DET:
                begin
                    case (sub)
                        m4te_pkg::DSUB_MINOR_A: t1_reg    <= prod_reg;
                        m4te_pkg::DSUB_MINOR_B: minor_reg <= m4te_pkg::sat32(minor_diff);
                        m4te_pkg::DSUB_PAIR:    pair_reg  <= m4te_pkg::sat32(prod_reg);
                        default:
                        begin
                            acc_reg <= det_sum;
                            if (step_reg == last_step)
                            begin
                                res_reg[0] <= m4te_pkg::sat32(det_sum);
                                res_reg[1] <= '0;
                                res_reg[2] <= '0;
                                res_reg[3] <= '0;
                            end
                        end
                    endcase
                end
                default: acc_reg <= acc_reg;
            endcase
        end
        if (emit_load)
        begin
            out_kind_reg    <= (op_reg == m4te_pkg::OP_DET) ? m4te_pkg::KIND_DET
                                                             : m4te_pkg::KIND_VECTOR;
            out_data_reg[0] <= res_reg[0];
            out_data_reg[1] <= res_reg[1];
            out_data_reg[2] <= res_reg[2];
            out_data_reg[3] <= res_reg[3];
        end
    end

    assign result.valid       = out_vld_reg;
    assign result.result_kind = out_kind_reg;
    assign result.out_0       = out_data_reg[0];
    assign result.out_1       = out_data_reg[1];
    assign result.out_2       = out_data_reg[2];
    assign result.out_3       = out_data_reg[3];

endmodule

`default_nettype wire

// ----- hdl/m4te_checker.sv -----
// ============================================================================
// m4te_checker
// Port-level checks for the matrix engine, bound to the top level.
// ============================================================================
`default_nettype none

module m4te_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic               out_kind,
    input wire logic signed [31:0] out_0,
    input wire logic signed [31:0] out_1,
    input wire logic signed [31:0] out_2,
    input wire logic signed [31:0] out_3
);

    // A stalled result stays valid and keeps out_0 and its kind.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_0) && $stable(out_kind))
        else $error("stalled result changed");

    // A determinant result carries zeros in the vector lanes.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == m4te_pkg::KIND_DET) |->
            (out_1 == 0) && (out_2 == 0) && (out_3 == 0))
        else $error("determinant result with nonzero lanes");

    // The engine does not accept a new command in the cycle after taking one.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("command taken while busy");

    // No result is pending right out of reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("result pending after reset");

endmodule

bind matrix4_transform_engine_core m4te_checker u_m4te_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_kind  (result.result_kind),
    .out_0     (result.out_0),
    .out_1     (result.out_1),
    .out_2     (result.out_2),
    .out_3     (result.out_3)
);

`default_nettype wire

// ----- tb/sv/tb.sv -----
// ============================================================================
// tb
// Self-checking testbench for matrix4_transform_engine_core.
// It drives column, scale, identity, transform and determinant commands with
// random idle gaps on both channels. A scoreboard object keeps its own copy
// of the held matrix and product buffer and checks every result field.
// ============================================================================
`timescale 1ns / 100ps
`default_nettype none

module tb;

    localparam int FRAC = 16;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_ITEMS = 1100;

    typedef struct {
        logic              kind;
        logic signed [31:0] val [4];
    } mat_result_t;

    // The scoreboard owns the matrix state and the queue of expected results.
    class matrix_scoreboard;
        logic signed [31:0] held [16];
        logic signed [31:0] prod [16];
        mat_result_t        pending [$];
        int                 errors;
        int                 seen;

        function new();
            foreach (held[n]) held[n] = '0;
            foreach (prod[n]) prod[n] = '0;
            errors = 0;
            seen   = 0;
        endfunction

        function longint clip32(longint x);
            if (x > 64'sd2147483647) return 64'sd2147483647;
            if (x < -64'sd2147483648) return -64'sd2147483648;
            return x;
        endfunction

        // Exact product, then floor shift by the fraction width.
        function longint qmul(longint a, longint b);
            longint p;
            p = a * b;
            return p >>> FRAC;
        endfunction

        function longint det_value();
            longint acc;
            longint pair;
            longint minor;
            longint term;
            int     cols [2];
            int     n;
            int     pos;
            acc = 0;
            for (int i = 0; i < 4; i++)
            begin
                pos = 0;
                for (int j = 0; j < 4; j++)
                begin
                    if (j == i)
                        continue;
                    n = 0;
                    for (int k = 0; k < 4; k++)
                        if (k != i && k != j)
                        begin
                            cols[n] = k;
                            n++;
                        end
                    pair  = clip32(qmul(held[4*i], held[1+4*j]));
                    minor = clip32(qmul(held[2+4*cols[0]], held[3+4*cols[1]])
                                 - qmul(held[3+4*cols[0]], held[2+4*cols[1]]));
                    term  = qmul(pair, minor);
                    if ((i % 2 == 1) != (pos % 2 == 1))
                        acc -= term;
                    else
                        acc += term;
                    pos++;
                end
            end
            return clip32(acc);
        endfunction

        // Called for every accepted command transaction.
        function void note_cmd(m4te_pkg::op_t op, logic [1:0] col, logic signed [31:0] e [4]);
            mat_result_t r;
            longint      s;
            case (op)
                m4te_pkg::OP_LOAD:
                    for (int k = 0; k < 4; k++) held[k+4*col] = e[k];
                m4te_pkg::OP_ADD:
                    for (int k = 0; k < 4; k++)
                        held[k+4*col] = 32'(clip32(longint'(held[k+4*col]) + longint'(e[k])));
                m4te_pkg::OP_SUB:
                    for (int k = 0; k < 4; k++)
                        held[k+4*col] = 32'(clip32(longint'(held[k+4*col]) - longint'(e[k])));
                m4te_pkg::OP_MATMUL:
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        s = 0;
                        for (int c = 0; c < 4; c++)
                            s += qmul(held[k+4*c], e[c]);
                        prod[k+4*col] = 32'(clip32(s));
                    end
                    if (col == 2'd3)
                        held = prod;
                end
                m4te_pkg::OP_SCALE:
                    for (int k = 0; k < 16; k++) held[k] = 32'(clip32(qmul(held[k], e[0])));
                m4te_pkg::OP_XFORM:
                begin
                    r.kind = m4te_pkg::KIND_VECTOR;
                    for (int k = 0; k < 4; k++)
                    begin
                        s = 0;
                        for (int c = 0; c < 4; c++)
                            s += qmul(held[k+4*c], e[c]);
                        r.val[k] = 32'(clip32(s));
                    end
                    pending.push_back(r);
                end
                m4te_pkg::OP_DET:
                begin
                    r.kind   = m4te_pkg::KIND_DET;
                    r.val[0] = 32'(det_value());
                    r.val[1] = '0;
                    r.val[2] = '0;
                    r.val[3] = '0;
                    pending.push_back(r);
                end
                default:
                    for (int k = 0; k < 16; k++)
                        held[k] = (k % 5 == 0) ? (32'sd1 <<< FRAC) : '0;
            endcase
        endfunction

        // Called for every accepted result transaction.
        function void check_result(logic kind, logic signed [31:0] got [4]);
            mat_result_t x;
            seen++;
            if (pending.size() == 0)
            begin
                $error("unexpected result transaction kind=%0d out_0=%0d", kind, got[0]);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (kind !== x.kind)
            begin
                $error("result_kind: expected %0d, actual %0d", x.kind, kind);
                errors++;
            end
            for (int k = 0; k < 4; k++)
                if (got[k] !== x.val[k])
                begin
                    $error("out_%0d: expected %0d, actual %0d", k, x.val[k], got[k]);
                    errors++;
                end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycles;
    int   sent;
    bit   calm;
    bit   buf_written [4];

    matrix_scoreboard sb;

    m4te_cmd_if item_ch ();
    m4te_rsp_if res_ch ();

    matrix4_transform_engine_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Watchdog: the slowest legal run is far below this cycle count.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL matrix4_transform_engine_core");
            $finish;
        end
    end

    // Mostly short gaps, sometimes a long one; none at all during calm phases.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Element values: extremes, small Q16.16 numbers, or raw 32-bit patterns.
    function automatic logic signed [31:0] pick_elem();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            case ($urandom_range(0, 5))
                0: return 32'sh7FFFFFFF;
                1: return 32'sh80000000;
                2: return '0;
                3: return -32'sd1;
                4: return 32'sh00010000;
                default: return -32'sh00010000;
            endcase
        end
        if (r < 75)
            return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        return $urandom;
    endfunction

    // Result sink: ready toggles with random stall lengths.
    initial
    begin
        int n;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            n = pick_gap();
            if (n > 0)
            begin
                res_ch.ready = 1'b0;
                repeat (n) @(negedge clk);
            end
            res_ch.ready = 1'b1;
            repeat ($urandom_range(1, 8) - 1) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        logic signed [31:0] got [4];
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got[0] = res_ch.out_0;
            got[1] = res_ch.out_1;
            got[2] = res_ch.out_2;
            got[3] = res_ch.out_3;
            sb.check_result(res_ch.result_kind, got);
        end
    end

    // Sends one command and waits for its transaction; returns at a falling edge.
    task automatic send_cmd(m4te_pkg::op_t op, logic [1:0] col, logic signed [31:0] e [4]);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid        = 1'b1;
        item_ch.opcode       = op;
        item_ch.column_index = col;
        item_ch.elem_0       = e[0];
        item_ch.elem_1       = e[1];
        item_ch.elem_2       = e[2];
        item_ch.elem_3       = e[3];
        do
            @(posedge clk);
        while (!item_ch.ready);
        sb.note_cmd(op, col, e);
        if (op == m4te_pkg::OP_MATMUL)
            buf_written[col] = 1'b1;
        sent++;
        @(negedge clk);
    endtask

    task automatic send_rand_elems(m4te_pkg::op_t op, logic [1:0] col);
        logic signed [31:0] e [4];
        foreach (e[k]) e[k] = pick_elem();
        send_cmd(op, col, e);
    endtask

    task automatic send_fixed(m4te_pkg::op_t op, logic [1:0] col, logic signed [31:0] v);
        logic signed [31:0] e [4];
        foreach (e[k]) e[k] = v;
        send_cmd(op, col, e);
    endtask

    // A full matrix product: columns 0..2 in random order, column 3 last.
    task automatic send_product();
        logic [1:0] order [3];
        logic [1:0] t;
        int         p;
        order = '{2'd0, 2'd1, 2'd2};
        for (int k = 2; k > 0; k--)
        begin
            p = $urandom_range(0, k);
            t = order[k];
            order[k] = order[p];
            order[p] = t;
        end
        foreach (order[k]) send_rand_elems(m4te_pkg::OP_MATMUL, order[k]);
        send_rand_elems(m4te_pkg::OP_MATMUL, 2'd3);
    endtask

    initial
    begin
        logic [1:0] col;
        int         r;
        sb     = new();
        cycles = 0;
        sent   = 0;
        calm   = 1'b0;
        foreach (buf_written[k]) buf_written[k] = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.opcode       = m4te_pkg::OP_LOAD;
        item_ch.column_index = '0;
        item_ch.elem_0       = '0;
        item_ch.elem_1       = '0;
        item_ch.elem_2       = '0;
        item_ch.elem_3       = '0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part: determinant and transform of the zero reset matrix,
        // saturation at both extremes, identity, a product and ignored columns.
        send_fixed(m4te_pkg::OP_DET, 2'd0, '0);
        send_fixed(m4te_pkg::OP_XFORM, 2'd2, 32'sh7FFFFFFF);
        for (int k = 0; k < 4; k++)
            send_fixed(m4te_pkg::OP_LOAD, k[1:0], 32'sh7FFFFFFF);
        send_fixed(m4te_pkg::OP_ADD, 2'd1, 32'sh7FFFFFFF);
        send_fixed(m4te_pkg::OP_SUB, 2'd2, 32'sh80000000);
        send_fixed(m4te_pkg::OP_SUB, 2'd0, 32'sh7FFFFFFF);
        send_fixed(m4te_pkg::OP_ADD, 2'd3, 32'sh80000000);
        send_fixed(m4te_pkg::OP_XFORM, 2'd1, 32'sh80000000);
        send_fixed(m4te_pkg::OP_DET, 2'd3, '0);
        send_fixed(m4te_pkg::OP_SCALE, 2'd1, 32'sh80000000);
        send_fixed(m4te_pkg::OP_IDENT, 2'd2, '0);
        send_fixed(m4te_pkg::OP_DET, 2'd1, '0);
        send_fixed(m4te_pkg::OP_SCALE, 2'd3, 32'sh00020000);
        send_fixed(m4te_pkg::OP_XFORM, 2'd0, -32'sh00010000);
        send_product();
        send_fixed(m4te_pkg::OP_XFORM, 2'd3, 32'sh00010000);
        send_fixed(m4te_pkg::OP_DET, 2'd2, '0);
        // Column 3 alone commits buffer values left from the earlier product.
        send_rand_elems(m4te_pkg::OP_MATMUL, 2'd3);
        send_fixed(m4te_pkg::OP_DET, 2'd0, '0);

        // Random part, in phases each chosen at random to be calm or gappy traffic.
        while (sent < RANDOM_ITEMS + 25)
        begin
            calm = ($urandom_range(0, 9) == 0);
            repeat (40)
            begin
                r = $urandom_range(0, 99);
                col = 2'($urandom_range(0, 3));
                if (r < 20)
                    send_product();
                else if (r < 30)
                    send_fixed(m4te_pkg::OP_IDENT, col, pick_elem());
                else if (r < 45)
                    send_rand_elems(m4te_pkg::OP_LOAD, col);
                else if (r < 52)
                    send_rand_elems(m4te_pkg::OP_ADD, col);
                else if (r < 59)
                    send_rand_elems(m4te_pkg::OP_SUB, col);
                else if (r < 64)
                begin
                    // A lone column 3 is only sent once every buffer column is set.
                    if (col == 2'd3 && !(buf_written[0] && buf_written[1] && buf_written[2]))
                        col = 2'($urandom_range(0, 2));
                    send_rand_elems(m4te_pkg::OP_MATMUL, col);
                end
                else if (r < 70)
                    send_rand_elems(m4te_pkg::OP_SCALE, col);
                else if (r < 85)
                    send_rand_elems(m4te_pkg::OP_XFORM, col);
                else
                    send_rand_elems(m4te_pkg::OP_DET, col);
            end
        end
        item_ch.valid = 1'b0;
        calm = 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        $display("Covered %0d commands of every opcode and %0d checked results.",
                 sent, sb.seen);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS matrix4_transform_engine_core");
        else
            $display("FAIL matrix4_transform_engine_core");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
hdl/m4te_pkg.sv
hdl/m4te_if.sv
hdl/m4te_ram.sv
hdl/matrix4_transform_engine_core.sv
hdl/m4te_checker.sv
tb/sv/tb.sv
